### hw/rtl/bitmap_frame_allocator_unit_assert.svh
// Assertion macros for the bitmap frame allocator.
// Expects clk_i and rst_ni in the including module's scope.
`ifndef BITMAP_FRAME_ALLOCATOR_UNIT_ASSERT_SVH
`define BITMAP_FRAME_ALLOCATOR_UNIT_ASSERT_SVH

// implication checked every clock edge outside reset
`define BFA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// consequence checked in the cycle after the antecedent
`define BFA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/bfa_pkg.sv
// Shared types and constants of the bitmap frame allocator.
// Used by bfa_ctrl, bfa_datapath and bitmap_frame_allocator_unit.
package bfa_pkg;

  localparam int FRAMES     = 4096;
  localparam int REGIONS    = 4;
  localparam int WORD_BITS  = 64;
  localparam int WORDS      = (FRAMES + WORD_BITS - 1) / WORD_BITS;
  localparam int BIT_W      = $clog2(WORD_BITS);
  localparam int WADDR_W    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int WCNT_W     = $clog2(WORDS + 1);
  localparam int FRAME_W    = WADDR_W + BIT_W;
  localparam int CNT_W      = $clog2(FRAMES + 1);
  localparam int REG_W      = (REGIONS > 1) ? $clog2(REGIONS) : 1;
  localparam int KCNT_W     = $clog2(REGIONS + 1);
  localparam int PAGE_SHIFT = 12;
  localparam int BASE_W     = 36;
  localparam int PAGES_W    = 13;
  localparam int ADDR_W     = 48;
  localparam int RSV_W      = 13;
  localparam int FIRST_W    = PAGES_W + REG_W;
  localparam int FIDX_W     = FIRST_W + 1;
  localparam int CFG_IDX_W  = 3;

  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_FREE  = 2'd1;
  localparam logic [1:0] OP_INIT  = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_OOM     = 2'd1;
  localparam logic [1:0] ST_OUTSIDE = 2'd2;
  localparam logic [1:0] ST_DFREE   = 2'd3;

  localparam logic CFG_SEL_BASE  = 1'b0;
  localparam logic CFG_SEL_PAGES = 1'b1;

  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [WADDR_W-1:0]   waddr_t;
  typedef logic [WCNT_W-1:0]    wcnt_t;
  typedef logic [BIT_W-1:0]     bitpos_t;
  typedef logic [FRAME_W-1:0]   frame_t;
  typedef logic [FRAME_W:0]     frame_ext_t;
  typedef logic [CNT_W-1:0]     cnt_t;
  typedef logic [KCNT_W-1:0]    kcnt_t;
  typedef logic [REG_W-1:0]     reg_idx_t;
  typedef logic [BASE_W-1:0]    base_t;
  typedef logic [PAGES_W-1:0]   pages_t;
  typedef logic [FIRST_W-1:0]   first_t;
  typedef logic [FIDX_W-1:0]    fidx_t;

  typedef struct packed {
    logic [1:0]        opcode;
    logic [ADDR_W-1:0] phys_address;
    logic [RSV_W-1:0]  reserved_count;
  } req_t;

  typedef struct packed {
    logic [ADDR_W-1:0] frame_address;
    logic [1:0]        status;
  } rsp_t;

  typedef struct packed {
    logic       load;
    logic       init_clr;
    logic       init_wr;
    logic       scan;
    logic       amap;
    logic       fmap;
    logic       frd;
    logic       fchk;
    logic       st_wr;
    logic [1:0] st_code;
  } cmd_t;

  typedef struct packed {
    logic init_more;
    logic scan_hit;
    logic scan_oob;
    logic scan_end;
    logic map_end;
    logic amap_hit;
    logic fmap_hit;
    logic f_over;
    logic bit_set;
  } sts_t;

endpackage

### hw/rtl/bfa_ctrl.sv
// Sequencer of the bitmap frame allocator: one transaction at a time.
// Depends on bfa_pkg; drives bfa_datapath through cmd_t and reads sts_t.
module bfa_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  logic [1:0]        opcode_i,
  input  bfa_pkg::sts_t     sts_i,
  output logic              busy,
  output logic              done_o,
  output bfa_pkg::cmd_t     cmd_o
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_INIT = 4'd1;
  localparam logic [3:0] S_SCAN = 4'd2;
  localparam logic [3:0] S_AMAP = 4'd3;
  localparam logic [3:0] S_FMAP = 4'd4;
  localparam logic [3:0] S_FRD  = 4'd5;
  localparam logic [3:0] S_FCHK = 4'd6;
  localparam logic [3:0] S_DONE = 4'd7;

  logic [3:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          case (opcode_i)
            bfa_pkg::OP_ALLOC: state_d = S_SCAN;
            bfa_pkg::OP_FREE:  state_d = S_FMAP;
            bfa_pkg::OP_INIT: begin
              cmd_o.init_clr = 1'b1;
              state_d        = S_INIT;
            end
            default: state_d = S_DONE;
          endcase
        end
      end
      S_INIT: begin
        if (sts_i.init_more) begin
          cmd_o.init_wr = 1'b1;
        end else begin
          state_d = S_DONE;
        end
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_hit) begin
          if (sts_i.scan_oob) begin
            cmd_o.st_wr   = 1'b1;
            cmd_o.st_code = bfa_pkg::ST_OOM;
            state_d       = S_DONE;
          end else begin
            state_d = S_AMAP;
          end
        end else if (sts_i.scan_end) begin
          cmd_o.st_wr   = 1'b1;
          cmd_o.st_code = bfa_pkg::ST_OOM;
          state_d       = S_DONE;
        end
      end
      S_AMAP: begin
        cmd_o.amap = 1'b1;
        if (sts_i.map_end) begin
          cmd_o.st_wr   = 1'b1;
          cmd_o.st_code = bfa_pkg::ST_OOM;
          state_d       = S_DONE;
        end else if (sts_i.amap_hit) begin
          state_d = S_DONE;
        end
      end
      S_FMAP: begin
        cmd_o.fmap = 1'b1;
        if (sts_i.map_end) begin
          cmd_o.st_wr   = 1'b1;
          cmd_o.st_code = bfa_pkg::ST_OUTSIDE;
          state_d       = S_DONE;
        end else if (sts_i.fmap_hit) begin
          state_d = S_FRD;
        end
      end
      S_FRD: begin
        if (sts_i.f_over) begin
          cmd_o.st_wr   = 1'b1;
          cmd_o.st_code = bfa_pkg::ST_OUTSIDE;
          state_d       = S_DONE;
        end else begin
          cmd_o.frd = 1'b1;
          state_d   = S_FCHK;
        end
      end
      S_FCHK: begin
        cmd_o.fchk = 1'b1;
        if (!sts_i.bit_set) begin
          cmd_o.st_wr   = 1'b1;
          cmd_o.st_code = bfa_pkg::ST_DFREE;
        end
        state_d = S_DONE;
      end
      S_DONE: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign busy   = (state_q != S_IDLE);
  assign done_o = (state_q == S_DONE);

endmodule

### hw/rtl/bfa_datapath.sv
// Datapath of the bitmap frame allocator: region registers, bitmap memory,
// scan and region walk counters, result registers. Depends on bfa_pkg.
module bfa_datapath (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  bfa_pkg::req_t                  req_i,
  input  logic                           cfg_we_i,
  input  logic [bfa_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [bfa_pkg::BASE_W-1:0]     cfg_data_i,
  input  bfa_pkg::cmd_t                  cmd_i,
  output bfa_pkg::sts_t                  sts_o,
  output bfa_pkg::rsp_t                  rsp_o
);

  bfa_pkg::base_t   base_q  [bfa_pkg::REGIONS];
  bfa_pkg::pages_t  pages_q [bfa_pkg::REGIONS];

  bfa_pkg::word_t   mem [bfa_pkg::WORDS];
  logic [bfa_pkg::WORDS-1:0] valid_q;

  bfa_pkg::word_t   rd_raw_q;
  logic             rd_vld_q;
  bfa_pkg::wcnt_t   wcnt_q;
  logic             chk_vld_q;
  bfa_pkg::waddr_t  chk_idx_q;
  bfa_pkg::kcnt_t   k_q;
  bfa_pkg::frame_t  rest_q;
  bfa_pkg::frame_t  frame_q;
  bfa_pkg::word_t   hit_word_q;
  bfa_pkg::first_t  first_q;
  bfa_pkg::fidx_t   fidx_q;
  bfa_pkg::base_t   page_q;
  bfa_pkg::cnt_t    cnt_q;
  logic [bfa_pkg::ADDR_W-1:0] addr_q;
  logic [1:0]       st_q;

  bfa_pkg::word_t   rd_word;
  bfa_pkg::bitpos_t ffz;
  bfa_pkg::frame_t  cand;
  bfa_pkg::reg_idx_t k_idx;
  bfa_pkg::base_t   cur_base;
  bfa_pkg::pages_t  cur_pages;
  logic             k_act;
  logic             amap_hit;
  logic             fmap_hit;
  bfa_pkg::base_t   alloc_page;
  logic [bfa_pkg::BASE_W:0] diff;
  bfa_pkg::fidx_t   fidx_next;
  bfa_pkg::wcnt_t   nwords;
  bfa_pkg::wcnt_t   fullw;
  bfa_pkg::word_t   init_word;
  logic             bit_set;
  logic             scan_rd;
  logic             we;
  bfa_pkg::waddr_t  wa;
  bfa_pkg::word_t   wd;
  logic             re;
  bfa_pkg::waddr_t  ra;
  bfa_pkg::reg_idx_t cfg_reg;

  assign rd_word = rd_vld_q ? rd_raw_q : '0;

  always_comb begin
    ffz = '0;
    for (int i = bfa_pkg::WORD_BITS - 1; i >= 0; i--) begin
      if (!rd_word[i]) ffz = bfa_pkg::bitpos_t'(i);
    end
  end

  assign cand       = {chk_idx_q, ffz};
  assign k_idx      = k_q[bfa_pkg::REG_W-1:0];
  assign cur_base   = base_q[k_idx];
  assign cur_pages  = pages_q[k_idx];
  assign k_act      = (k_q < bfa_pkg::kcnt_t'(bfa_pkg::REGIONS)) && (cur_pages != '0);
  assign amap_hit   = k_act && (bfa_pkg::fidx_t'(rest_q) < bfa_pkg::fidx_t'(cur_pages));
  assign alloc_page = cur_base + bfa_pkg::base_t'(rest_q);
  assign diff       = {1'b0, page_q} - {1'b0, cur_base};
  assign fmap_hit   = k_act && !diff[bfa_pkg::BASE_W]
                      && (diff[bfa_pkg::BASE_W-1:0] < bfa_pkg::base_t'(cur_pages));
  assign fidx_next  = bfa_pkg::fidx_t'(first_q)
                      + bfa_pkg::fidx_t'(diff[bfa_pkg::PAGES_W-1:0]);
  assign nwords     = bfa_pkg::wcnt_t'((cnt_q + bfa_pkg::cnt_t'(bfa_pkg::WORD_BITS - 1))
                      >> bfa_pkg::BIT_W);
  assign fullw      = bfa_pkg::wcnt_t'(cnt_q >> bfa_pkg::BIT_W);
  assign init_word  = (wcnt_q < fullw) ? '1
                      : ((bfa_pkg::word_t'(1) << cnt_q[bfa_pkg::BIT_W-1:0])
                         - bfa_pkg::word_t'(1));
  assign bit_set    = rd_word[fidx_q[bfa_pkg::BIT_W-1:0]];
  assign scan_rd    = cmd_i.scan && (wcnt_q < bfa_pkg::wcnt_t'(bfa_pkg::WORDS));

  always_comb begin
    we = 1'b0;
    wa = '0;
    wd = '0;
    if (cmd_i.init_wr) begin
      we = 1'b1;
      wa = wcnt_q[bfa_pkg::WADDR_W-1:0];
      wd = init_word;
    end else if (cmd_i.amap && amap_hit) begin
      we = 1'b1;
      wa = frame_q[bfa_pkg::FRAME_W-1:bfa_pkg::BIT_W];
      wd = hit_word_q | (bfa_pkg::word_t'(1) << frame_q[bfa_pkg::BIT_W-1:0]);
    end else if (cmd_i.fchk && bit_set) begin
      we = 1'b1;
      wa = fidx_q[bfa_pkg::FRAME_W-1:bfa_pkg::BIT_W];
      wd = rd_word & ~(bfa_pkg::word_t'(1) << fidx_q[bfa_pkg::BIT_W-1:0]);
    end
  end

  assign re = scan_rd || cmd_i.frd;
  assign ra = cmd_i.frd ? fidx_q[bfa_pkg::FRAME_W-1:bfa_pkg::BIT_W]
                        : wcnt_q[bfa_pkg::WADDR_W-1:0];

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      rd_raw_q <= mem[ra];
    end
  end

  assign cfg_reg = cfg_idx_i[bfa_pkg::CFG_IDX_W-1:1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < bfa_pkg::REGIONS; r++) begin
        base_q[r]  <= '0;
        pages_q[r] <= '0;
      end
    end else if (cfg_we_i && (int'(cfg_reg) < bfa_pkg::REGIONS)) begin
      if (cfg_idx_i[0] == bfa_pkg::CFG_SEL_PAGES) begin
        pages_q[cfg_reg] <= cfg_data_i[bfa_pkg::PAGES_W-1:0];
      end else begin
        base_q[cfg_reg] <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= '0;
      rd_vld_q  <= 1'b0;
      wcnt_q    <= '0;
      chk_vld_q <= 1'b0;
      k_q       <= '0;
    end else begin
      if (cmd_i.init_clr) begin
        valid_q <= '0;
      end else if (we) begin
        valid_q[wa] <= 1'b1;
      end
      if (re) begin
        rd_vld_q <= valid_q[ra];
      end
      if (cmd_i.load) begin
        wcnt_q    <= '0;
        chk_vld_q <= 1'b0;
        k_q       <= '0;
      end else begin
        if (cmd_i.init_wr || scan_rd) begin
          wcnt_q <= wcnt_q + bfa_pkg::wcnt_t'(1);
        end
        if (cmd_i.scan) begin
          chk_vld_q <= scan_rd;
        end
        if ((cmd_i.amap && k_act && !amap_hit) || (cmd_i.fmap && k_act && !fmap_hit)) begin
          k_q <= k_q + bfa_pkg::kcnt_t'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      page_q  <= req_i.phys_address[bfa_pkg::ADDR_W-1:bfa_pkg::PAGE_SHIFT];
      cnt_q   <= (int'(req_i.reserved_count) > bfa_pkg::FRAMES)
                 ? bfa_pkg::cnt_t'(bfa_pkg::FRAMES) : bfa_pkg::cnt_t'(req_i.reserved_count);
      first_q <= '0;
      addr_q  <= '0;
      st_q    <= bfa_pkg::ST_OK;
    end else begin
      if (cmd_i.scan) begin
        chk_idx_q <= wcnt_q[bfa_pkg::WADDR_W-1:0];
        if (chk_vld_q && !(&rd_word)) begin
          frame_q    <= cand;
          rest_q     <= cand;
          hit_word_q <= rd_word;
        end
      end
      if (cmd_i.amap && k_act) begin
        if (amap_hit) begin
          addr_q <= {alloc_page, {bfa_pkg::PAGE_SHIFT{1'b0}}};
        end else begin
          rest_q <= rest_q - bfa_pkg::frame_t'(cur_pages);
        end
      end
      if (cmd_i.fmap && k_act) begin
        if (fmap_hit) begin
          fidx_q <= fidx_next;
        end else begin
          first_q <= first_q + bfa_pkg::first_t'(cur_pages);
        end
      end
      if (cmd_i.st_wr) begin
        st_q <= cmd_i.st_code;
      end
    end
  end

  assign sts_o.init_more = (wcnt_q < nwords);
  assign sts_o.scan_hit  = chk_vld_q && !(&rd_word);
  assign sts_o.scan_oob  = (bfa_pkg::frame_ext_t'(cand) >= bfa_pkg::frame_ext_t'(bfa_pkg::FRAMES));
  assign sts_o.scan_end  = !chk_vld_q && (wcnt_q == bfa_pkg::wcnt_t'(bfa_pkg::WORDS));
  assign sts_o.map_end   = !k_act;
  assign sts_o.amap_hit  = amap_hit;
  assign sts_o.fmap_hit  = fmap_hit;
  assign sts_o.f_over    = (fidx_q >= bfa_pkg::fidx_t'(bfa_pkg::FRAMES));
  assign sts_o.bit_set   = bit_set;

  assign rsp_o.frame_address = addr_q;
  assign rsp_o.status        = st_q;

endmodule

### hw/rtl/bitmap_frame_allocator_unit.sv
// Top level of the bitmap frame allocator: sequencer plus datapath.
// Depends on bfa_pkg, bfa_ctrl, bfa_datapath and the assertion macro header.
//
//   channel   handshake              payload
//   request   start high, busy low   req_i (bfa_pkg::req_t)
//   result    done_o, one cycle      res_o (bfa_pkg::rsp_t)
//   config    cfg_we_i               cfg_idx_i, cfg_data_i
//
// One transaction at a time; the bitmap memory has one read and one write port.
// Allocate: up to 64 word reads pipelined one a cycle, then a region walk that maps
// the free frame to an address. Free: a region walk, then a word read, check and clear.
// Initialize: clears the bitmap, then writes up to 64 words of reserved frames.
// Reset leaves every frame free and every region empty; no clearing pass.
// done_o marks the result for one cycle; the receiver cannot stall it.
`include "bitmap_frame_allocator_unit_assert.svh"

module bitmap_frame_allocator_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  bfa_pkg::req_t                  req_i,
  output logic                           done_o,
  output bfa_pkg::rsp_t                  res_o,
  input  logic                           cfg_we_i,
  input  logic [bfa_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [bfa_pkg::BASE_W-1:0]     cfg_data_i
);

  bfa_pkg::cmd_t cmd;
  bfa_pkg::sts_t sts;

  bfa_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .opcode_i (req_i.opcode),
    .sts_i    (sts),
    .busy     (busy),
    .done_o   (done_o),
    .cmd_o    (cmd)
  );

  bfa_datapath u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .rsp_o      (res_o)
  );

  `BFA_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted transaction left busy low")
  `BFA_ASSERT_NEXT(a_done_single, done_o, !done_o && !busy, "result strobe not a single pulse")
  `BFA_ASSERT_IMP(a_err_addr_zero, done_o && (res_o.status != bfa_pkg::ST_OK),
                  res_o.frame_address == '0, "error result carries an address")
  `BFA_ASSERT_IMP(a_done_busy, done_o, busy, "result strobe outside a transaction")

endmodule
